// File: rtl/srf_pkg.sv
// ----------------------------------------------------------------------------
// srf_pkg: shared types and constants of the sliding rank filter
// Window size, pixel and job formats, and front-end state codes.
// ----------------------------------------------------------------------------
package srf_pkg;

  localparam int WIN     = 7;                 // pixels per window
  localparam int PEND    = WIN - 1;           // pending pixels held by the front end
  localparam int PIX_W   = 8;
  localparam int RSEL_W  = 3;                 // width of the rank register
  localparam int CNT_W   = $clog2(WIN);       // holds 0 .. PEND
  localparam int RANK_W  = $clog2(WIN);       // sorted position 0 .. WIN-1
  localparam int QDEPTH  = 2;                 // job queue entries
  localparam int QAW     = $clog2(QDEPTH);

  localparam logic [RSEL_W-1:0] RANK_RESET = RSEL_W'(3);

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [RANK_W-1:0] rank_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             frame_end;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last_out;
  } out_t;

  // One complete window ready for ranking.
  typedef struct packed {
    pix_t [WIN-1:0] win;
    logic           last;
  } job_t;

  // Handshake between queue and its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic {
    FR_FILL,
    FR_FLUSH
  } front_state_t;

endpackage

// File: rtl/srf_front.sv
// ----------------------------------------------------------------------------
// srf_front: pixel intake and window builder
// Holds pending pixels, issues one window per full step and walks the
// padded flush at frame end.
// ----------------------------------------------------------------------------
module srf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  srf_pkg::in_t   in_data,
  input  srf_pkg::q_stat_t q_stat,
  output logic           push,
  output srf_pkg::job_t  push_job
);
  import srf_pkg::*;

  front_state_t      state, state_next;
  pix_t [PEND-1:0]   win, win_next;
  logic [CNT_W-1:0]  count, count_next;
  pix_t              last_pix, last_pix_next;
  logic              accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_FILL;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    win      <= win_next;
    last_pix <= last_pix_next;
  end

  always_comb begin
    state_next    = state;
    win_next      = win;
    count_next    = count;
    last_pix_next = last_pix;
    push          = 1'b0;
    push_job      = '0;
    in_ready      = 1'b0;
    accept        = 1'b0;
    unique case (state)
      FR_FILL: begin
        in_ready = !q_stat.full;
        accept   = in_valid && in_ready;
        if (accept) begin
          if (count == CNT_W'(PEND)) begin
            // full window: issue it and advance by one
            push = 1'b1;
            for (int i = 0; i < PEND; i++) push_job.win[i] = win[i];
            push_job.win[PEND] = in_data.pixel_in;
            push_job.last      = 1'b0;
            for (int i = 0; i < PEND - 1; i++) win_next[i] = win[i + 1];
            win_next[PEND-1] = in_data.pixel_in;
          end else begin
            for (int i = 0; i < PEND; i++) begin
              if (CNT_W'(i) == count) win_next[i] = in_data.pixel_in;
            end
            count_next = count + CNT_W'(1);
          end
          if (in_data.frame_end) begin
            last_pix_next = in_data.pixel_in;
            state_next    = FR_FLUSH;
          end
        end
      end
      FR_FLUSH: begin
        if (!q_stat.full) begin
          // pad the oldest pending pixel's window with the last pixel
          push = 1'b1;
          for (int i = 0; i < PEND; i++) begin
            push_job.win[i] = (CNT_W'(i) < count) ? win[i] : last_pix;
          end
          push_job.win[PEND] = last_pix;
          push_job.last      = (count == CNT_W'(1));
          for (int i = 0; i < PEND - 1; i++) win_next[i] = win[i + 1];
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) state_next = FR_FILL;
        end
      end
      default: state_next = FR_FILL;
    endcase
  end

endmodule

// File: rtl/srf_queue.sv
// ----------------------------------------------------------------------------
// srf_queue: short job queue
// Decouples the window builder from the ranking pipeline.
// ----------------------------------------------------------------------------
module srf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  srf_pkg::job_t    push_job,
  input  logic             pop,
  output srf_pkg::job_t    head,
  output srf_pkg::q_stat_t q_stat
);
  import srf_pkg::*;

  job_t [QDEPTH-1:0] mem;
  logic [QAW-1:0]    wr_ptr, rd_ptr;
  logic [QAW:0]      fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + QAW'(1);
      unique case ({push, pop})
        2'b10:   fill <= fill + (QAW+1)'(1);
        2'b01:   fill <= fill - (QAW+1)'(1);
        default: fill <= fill;
      endcase
    end
    if (push) mem[wr_ptr] <= push_job;
  end

  assign head         = mem[rd_ptr];
  assign q_stat.full  = (fill == (QAW+1)'(QDEPTH));
  assign q_stat.empty = (fill == '0);

endmodule

// File: rtl/srf_back.sv
// ----------------------------------------------------------------------------
// srf_back: rank selection pipeline
// Stage one ranks every window entry by compare-and-count; stage two picks
// the entry at the requested rank into the output register.
// ----------------------------------------------------------------------------
module srf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  srf_pkg::q_stat_t            q_stat,
  input  srf_pkg::job_t               head,
  output logic                        pop,
  input  logic [srf_pkg::RSEL_W-1:0]  rank_select,
  output logic                        out_valid,
  input  logic                        out_ready,
  output srf_pkg::out_t               out_data
);
  import srf_pkg::*;

  logic             s1_valid;
  pix_t  [WIN-1:0]  s1_win;
  rank_t [WIN-1:0]  s1_rank;
  logic             s1_last;
  rank_t [WIN-1:0]  rank_calc;
  rank_t            rsel;
  pix_t             pick;
  logic             out_free, s1_adv;

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = !s1_valid || out_free;
  assign pop      = !q_stat.empty && s1_adv;

  // Stable rank: count entries smaller, ties broken by position.
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      rank_calc[i] = '0;
      for (int j = 0; j < WIN; j++) begin
        if (j != i) begin
          if ((head.win[j] < head.win[i]) || ((head.win[j] == head.win[i]) && (j < i)))
            rank_calc[i] = rank_calc[i] + RANK_W'(1);
        end
      end
    end
  end

  always_comb begin
    if (int'(rank_select) > PEND) rsel = RANK_W'(PEND);
    else                          rsel = RANK_W'(rank_select);
    pick = '0;
    for (int i = 0; i < WIN; i++) begin
      if (s1_rank[i] == rsel) pick = s1_win[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv)   s1_valid  <= !q_stat.empty;
      if (out_free) out_valid <= s1_valid;
    end
    if (pop) begin
      s1_win  <= head.win;
      s1_rank <= rank_calc;
      s1_last <= head.last;
    end
    if (out_free && s1_valid) begin
      out_data.pixel_out <= pick;
      out_data.last_out  <= s1_last;
    end
  end

endmodule

// File: rtl/sliding_rank_filter_7.sv
// ----------------------------------------------------------------------------
// sliding_rank_filter_7: seven-tap running rank (median) filter
// Replaces each pixel by the selected rank of itself and the next six pixels.
// ----------------------------------------------------------------------------
// Usage: pixels stream in at one per cycle while in_ready is high. The
// result for a pixel leaves once the six pixels after it have arrived, so
// the first six pixels of a frame produce nothing. A pixel marked frame_end
// triggers a flush: in_ready stays low while the front end issues one window
// per still-pending pixel (up to six), each padded by repeating the frame's
// last pixel; last_out marks the final result. Results pass a two-register
// ranking pipeline (rank by compare-and-count, then select), with a two-entry
// window queue in front of it, so a stalled output only back-pressures the
// input once the queue fills. rank_select (reset 3, the median) picks the
// sorted position; values above 6 select the maximum. The config channel is
// always ready; write it only while the filter is idle.
// ----------------------------------------------------------------------------
module sliding_rank_filter_7 (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  srf_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output srf_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [srf_pkg::RSEL_W-1:0]  cfg_data
);
  import srf_pkg::*;

  logic [RSEL_W-1:0] rank_select;
  q_stat_t           q_stat;
  logic              push, pop;
  job_t              push_job, head;

  // Rank register: take every config request.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_select <= RANK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rank_select <= cfg_data;
    end
  end

  // Front end: accept pixels, build windows, drive the frame-end flush.
  srf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  // Window queue: hold issued windows until the ranking pipe takes them.
  srf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Back end: rank and select, registered output.
  srf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .head        (head),
    .pop         (pop),
    .rank_select (rank_select),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  // A frame end always leaves at least one window to flush.
  a_flush_holds_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.frame_end) |=> !in_ready)
    else $error("input accepted right after frame end");

  // Never write a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into full queue");

  // Never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

// File: sim/sliding_rank_filter_7_test.sv
// ----------------------------------------------------------------------------
// sliding_rank_filter_7_test: self-checking bench for the seven-tap rank filter
// Streams framed pixels through the filter under random idling and one long
// output stall. A scoreboard ranks each seven-pixel window in software,
// padding at frame end, and compares every result field by field, in order.
// ----------------------------------------------------------------------------
module sliding_rank_filter_7_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srf_pkg::*;

  localparam int QUIET_LIMIT = 1000;  // cycles with no accepted request
  localparam int DRAIN_WAIT  = 16;    // flush + queue + ranking pipeline
  localparam int HOLD_CYCLES = 150;   // long output stall to back up the input
  localparam int HOLD_AFTER  = 40;    // results seen before the stall starts
  localparam int PHASE_ITEMS = 20;    // pixels per rank setting

  // Rank expectations: collect the pending pixels of the current frame and
  // emit one expected result per complete (or end-of-frame padded) window.
  class rank_scoreboard;
    pix_t              frame_pix[$];
    out_t              expected[$];
    logic [RSEL_W-1:0] rank_sel;
    int                errors;

    function new();
      rank_sel = RANK_RESET;
      errors   = 0;
    endfunction

    function void set_rank(logic [RSEL_W-1:0] r);
      rank_sel = r;
    endfunction

    // Pad the window with its last pixel, sort ascending, pick the rank.
    function pix_t window_rank(pix_t win[$]);
      pix_t sorted[$];
      int   idx;
      sorted = win;
      while (sorted.size() < WIN) sorted = {sorted, win[win.size()-1]};
      sorted.sort();
      idx = (int'(rank_sel) >= WIN) ? WIN - 1 : int'(rank_sel);
      return sorted[idx];
    endfunction

    function void note_pixel(in_t item);
      out_t res;
      frame_pix = {frame_pix, item.pixel_in};
      if (frame_pix.size() == WIN) begin
        res.pixel_out = window_rank(frame_pix);
        res.last_out  = 1'b0;
        expected = {expected, res};
        void'(frame_pix.pop_front());
      end
      // Flush every pending pixel at frame end; flag the final one.
      if (item.frame_end) begin
        while (frame_pix.size() > 0) begin
          res.pixel_out = window_rank(frame_pix);
          res.last_out  = (frame_pix.size() == 1);
          expected = {expected, res};
          void'(frame_pix.pop_front());
        end
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result pixel_out=%0d last_out=%0b",
                   $realtime, got.pixel_out, got.last_out);
        return;
      end
      want = expected.pop_front();
      if (got.pixel_out !== want.pixel_out || got.last_out !== want.last_out) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch pixel_out exp %0d got %0d, last_out exp %0b got %0b",
                   $realtime, want.pixel_out, got.pixel_out, want.last_out, got.last_out);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  in_t               in_data;
  logic              out_valid;
  logic              out_ready;
  out_t              out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [RSEL_W-1:0] cfg_data;

  rank_scoreboard sb;
  bit             calm;          // set during one phase: no idling on either side
  int             results_seen;
  int             quiet;

  sliding_rank_filter_7 uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check accepted results and watch for a stuck pipeline; sample at the
  // rising edge, where all inputs have been stable since the falling edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
        results_seen++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("sliding_rank_filter_7_test: done, errors");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off once traffic is
  // flowing so the window queue fills and the filter stalls its input.
  initial begin
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 13);
    end
  end

  // Offer one pixel request; idle first at random. Leave valid high on
  // return so a following request does not toggle it within one step.
  task automatic send_pixel(input pix_t pix, input logic last);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_t'{pixel_in: pix, frame_end: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(in_data);
    @(negedge clk);
  endtask

  task automatic send_frame(input pix_t frame[$]);
    foreach (frame[i]) send_pixel(frame[i], i == frame.size() - 1);
  endtask

  // Drop valid, wait until every expected result is back, then let the
  // pipeline settle before touching the rank register.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_rank(input logic [RSEL_W-1:0] r);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_rank(r);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    pix_t              frame[$];
    pix_t              pix;
    pix_t              prev;
    logic [RSEL_W-1:0] rank_plan[8];
    int                len;
    int                sent;

    sb           = new();
    calm         = 1'b0;
    results_seen = 0;
    quiet        = 0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    prev         = '0;
    rank_plan    = '{3'd0, 3'd6, 3'd7, 3'd5, 3'd1, 3'd2, 3'd4, 3'd3};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames at the reset rank (median): a single pixel, a frame
    // shorter than the window, exactly one window, and one of ten pixels.
    frame = '{8'd255};
    send_frame(frame);
    frame = '{8'd0, 8'd255, 8'd128};
    send_frame(frame);
    frame = '{8'd9, 8'd200, 8'd0, 8'd255, 8'd64, 8'd3, 8'd128};
    send_frame(frame);
    frame = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h00, 8'hFF, 8'h0F, 8'hF0, 8'hFF, 8'h00};
    send_frame(frame);

    // Random phases: switch the rank between frames, covering minimum,
    // maximum and the out-of-range code, then send random-length frames.
    foreach (rank_plan[ph]) begin
      drain();
      write_rank(rank_plan[ph]);
      calm = (ph == 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        frame.delete();
        repeat (len) begin
          case ($urandom_range(9))
            0:       pix = 8'd0;
            1:       pix = 8'd255;
            2:       pix = prev;          // repeat to exercise ties
            default: pix = pix_t'($urandom_range(255));
          endcase
          frame = {frame, pix};
          prev = pix;
        end
        send_frame(frame);
        sent += len;
      end
    end
    calm = 1'b0;
    drain();

    if (sb.errors == 0 && sb.expected.size() == 0)
      $display("sliding_rank_filter_7_test: done, clean");
    else
      $display("sliding_rank_filter_7_test: done, errors");
    $finish;
  end

endmodule
